### rtl/rsame_pkg.sv
// ----------------------------------------------------------------------------
// rsame_pkg
// shared widths and register indexes of the modular exponentiation unit
// ----------------------------------------------------------------------------
package rsame_pkg;

	// operand width of the arithmetic (8 to 32)
	localparam int WIDTH = 32;
	// width of the value, result and register fields on the ports
	localparam int DATA_W = 32;
	// bit counter of one modular multiply
	localparam int CNT_W = $clog2(WIDTH);
	// configuration register indexes
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [IDX_W-1:0] REG_PUB_EXP = 2'd1;
	localparam logic [IDX_W-1:0] REG_PRIV_EXP = 2'd2;
	// opcode of the input transaction
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

endpackage

### rtl/rsa_modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_unit
// modular exponentiation, right-to-left square and multiply
// ----------------------------------------------------------------------------
// usage:
//   configure modulus (index 0), public exponent (1) and private exponent (2)
//   through cfg_we / cfg_index / cfg_data while the unit is idle
//   the input channel carries value on s_tdata and opcode on s_tuser
//   (0 encrypt with public exponent, 1 decrypt with private exponent)
//   the output channel returns value^exponent mod modulus on m_tdata
// timing:
//   one input transaction at a time; s_tready is low while an item is worked
//   every modular multiply runs bit serially on one shared unit,
//   one operand bit per cycle
//   per item: 1 base reduction, then per exponent bit up to its highest set
//   bit one optional multiply and one squaring (the squaring after the top
//   bit is skipped), then a handoff through the final state to the output
//   register; a zero exponent needs only the base reduction, and a modulus
//   below 2 skips all multiplies
// reset: registers return to modulus 2 and both exponents 1, unit idle
// stall: the result waits in the output register; a finished item holds in
//   its final state until the output register is free
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_unit
	import rsame_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	// input channel
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tuser,   // [0] opcode
	// output channel
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata    // [31:0] result
);

	// sequencer state codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;  // base mod n, as 1 * value
	localparam logic [2:0] ST_MUL  = 3'd2;  // acc * base
	localparam logic [2:0] ST_SQR  = 3'd3;  // base * base
	localparam logic [2:0] ST_FIN  = 3'd4;  // hand result to output register

	// configuration registers
	logic [DATA_W-1:0] modulus_q;
	logic [DATA_W-1:0] pub_exp_q;
	logic [DATA_W-1:0] priv_exp_q;

	// sequencer and operands
	logic [2:0]       state_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] exp_q;

	// shared modular multiplier
	logic [WIDTH-1:0] mm_a_q;
	logic [WIDTH-1:0] mm_b_q;   // multiplier bits, msb first
	logic [WIDTH-1:0] mm_r_q;   // partial remainder
	logic [CNT_W-1:0] mm_cnt_q;

	// output register
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;

	logic [WIDTH-1:0] n;
	logic [WIDTH+1:0] mm_t;
	logic [WIDTH+1:0] mm_n1;
	logic [WIDTH+1:0] mm_n2;
	logic [WIDTH+1:0] mm_sel;
	logic [WIDTH-1:0] prod;
	logic             mm_run;
	logic             mm_last;
	logic             s_accept;
	logic             out_free;

	// after a multiply completes
	logic [WIDTH-1:0] nxt_acc;
	logic [WIDTH-1:0] nxt_base;
	logic [WIDTH-1:0] nxt_exp;
	logic             nxt_fin;
	logic [2:0]       nxt_op;
	logic [WIDTH-1:0] nxt_a;

	assign n = modulus_q[WIDTH-1:0];

	// one bit step: r = (2r + bit*a) mod n, with 2r + a below 3n
	assign mm_t  = {1'b0, mm_r_q, 1'b0} + (mm_b_q[WIDTH-1] ? {2'b00, mm_a_q} : '0);
	assign mm_n1 = {2'b00, n};
	assign mm_n2 = {1'b0, n, 1'b0};

	always_comb begin
		if (mm_t >= mm_n2) begin
			mm_sel = mm_t - mm_n2;
		end else if (mm_t >= mm_n1) begin
			mm_sel = mm_t - mm_n1;
		end else begin
			mm_sel = mm_t;
		end
	end

	assign prod    = mm_sel[WIDTH-1:0];
	assign mm_run  = state_q inside {ST_RED, ST_MUL, ST_SQR};
	assign mm_last = mm_run && (mm_cnt_q == CNT_W'(WIDTH - 1));

	// what follows the multiply that finishes in this cycle
	always_comb begin
		nxt_acc  = acc_q;
		nxt_base = base_q;
		nxt_exp  = exp_q;
		case (state_q)
			ST_RED: begin
				nxt_base = prod;
			end
			ST_MUL: begin
				nxt_acc = prod;
			end
			ST_SQR: begin
				nxt_base = prod;
				nxt_exp  = exp_q >> 1;
			end
			default: begin
			end
		endcase
		if (state_q == ST_MUL) begin
			// the squaring after the top set bit is not needed
			nxt_fin = (nxt_exp >> 1) == '0;
			nxt_op  = ST_SQR;
		end else begin
			nxt_fin = nxt_exp == '0;
			nxt_op  = nxt_exp[0] ? ST_MUL : ST_SQR;
		end
		nxt_a = (nxt_op == ST_MUL) ? nxt_acc : nxt_base;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= DATA_W'(2);
			pub_exp_q  <= DATA_W'(1);
			priv_exp_q <= DATA_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_PUB_EXP:  pub_exp_q  <= cfg_data;
				REG_PRIV_EXP: priv_exp_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						// a modulus below 2 leaves only the residue zero
						state_q <= (n < WIDTH'(2)) ? ST_FIN : ST_RED;
					end
				end
				ST_RED, ST_MUL, ST_SQR: begin
					if (mm_last) begin
						state_q <= nxt_fin ? ST_FIN : nxt_op;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operand registers and the shared multiplier
	always_ff @(posedge clk) begin
		if (s_accept) begin
			acc_q    <= (n < WIDTH'(2)) ? '0 : WIDTH'(1);
			exp_q    <= (s_tuser == OP_DECRYPT) ? priv_exp_q[WIDTH-1:0]
			                                    : pub_exp_q[WIDTH-1:0];
			// base reduction runs as 1 * value
			mm_a_q   <= WIDTH'(1);
			mm_b_q   <= s_tdata[WIDTH-1:0];
			mm_r_q   <= '0;
			mm_cnt_q <= '0;
		end else if (mm_last) begin
			acc_q    <= nxt_acc;
			base_q   <= nxt_base;
			exp_q    <= nxt_exp;
			mm_a_q   <= nxt_a;
			mm_b_q   <= nxt_base;
			mm_r_q   <= '0;
			mm_cnt_q <= '0;
		end else if (mm_run) begin
			mm_r_q   <= prod;
			mm_b_q   <= {mm_b_q[WIDTH-2:0], 1'b0};
			mm_cnt_q <= mm_cnt_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= DATA_W'(acc_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### rtl/rsame_check.sv
// ----------------------------------------------------------------------------
// rsame_check
// port level checks of the modular exponentiation unit
// ----------------------------------------------------------------------------
module rsame_check
	import rsame_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped under stall");

	// one item at a time: busy right after an accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item in work");

	// a new result shows up together with the return to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result appeared while sequencer still busy");

	// leaving busy means a result was just loaded
	a_idle_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("returned to idle without a result");

endmodule

bind rsa_modular_exponentiation_unit rsame_check u_rsame_check (.*);

### tb/rsame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsame_checker
// watches the ports of the exponentiation unit, predicts each power and
// compares it with the returned result, oldest first
// ----------------------------------------------------------------------------
module rsame_checker
	import rsame_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,
	output int                errors,
	output int                outstanding
);

	// own copy of the key registers
	logic [WIDTH-1:0]  key_modulus;
	logic [WIDTH-1:0]  key_pub_exp;
	logic [WIDTH-1:0]  key_priv_exp;
	// powers still owed by the unit, oldest first
	logic [DATA_W-1:0] powers_q[$];
	logic [DATA_W-1:0] want_power;

	// right-to-left binary exponentiation, every product reduced at once
	function automatic logic [DATA_W-1:0] modexp(input logic [WIDTH-1:0] base,
		input logic [WIDTH-1:0] expo, input logic [WIDTH-1:0] modulus);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] m;
		acc = 64'd1;
		m = 64'(modulus);
		// modulus below 2: only the residue zero
		if (m < 64'd2)
			return '0;
		sq = 64'(base);
		sq = sq % m;
		for (int i = 0; i < WIDTH; i++) begin
			if (expo[i])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc[DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_modulus <= 2;
			key_pub_exp <= 1;
			key_priv_exp <= 1;
			powers_q.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			// prediction uses the key as it stood before this edge
			if (s_tvalid && s_tready)
				powers_q.push_back(modexp(s_tdata[WIDTH-1:0],
					(s_tuser == OP_DECRYPT) ? key_priv_exp : key_pub_exp, key_modulus));
			if (m_tvalid && m_tready) begin
				if (powers_q.size() == 0) begin
					$error("result: no transaction pending, actual %h", m_tdata);
					errors <= errors + 1;
				end else begin
					want_power = powers_q.pop_front();
					if (m_tdata !== want_power) begin
						$error("result mismatch: expected %h, actual %h", want_power, m_tdata);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODULUS: key_modulus <= cfg_data[WIDTH-1:0];
					REG_PUB_EXP: key_pub_exp <= cfg_data[WIDTH-1:0];
					REG_PRIV_EXP: key_priv_exp <= cfg_data[WIDTH-1:0];
					default: ;
				endcase
			end
			outstanding <= powers_q.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// regression of the modular exponentiation unit: directed keys and values
// first, then random key settings with random traffic and random stalls on
// both channels; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
	import rsame_pkg::*;

	// worst item: all-ones exponent, the slowest case for the unit
	localparam int MAX_LATENCY = 2100;
	// cycles without any transaction before the run is declared hung
	localparam int WATCHDOG_LIMIT = 20000;
	// random part: key settings and items per setting
	localparam int RAND_KEYS = 8;
	localparam int ITEMS_PER_KEY = 34;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [31:0] value
	logic              s_tuser;   // [0] opcode
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [31:0] result

	int errors;
	int outstanding;
	int idle_cycles;
	int items_sent;
	int decrypts_sent;
	int keys_loaded;
	// when set, neither side inserts idle cycles
	bit no_gaps;

	// 10 ns clock, first rising edge at 5 ns
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	rsa_modular_exponentiation_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	rsame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// watchdog: any transaction on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rsa_modular_exponentiation_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: per result a random stall, taken once the result
	// is already waiting so that backpressure really hits the output register
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(16, 0);
			if (stall > 0) begin
				m_tready <= 1'b0;
				do @(posedge clk); while (!m_tvalid);
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// one input transaction, preceded by a random gap
	task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(16, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (op == OP_DECRYPT)
			decrypts_sent++;
	endtask

	// stop sending and let every owed result come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// new key, written only with the unit idle
	task automatic load_key(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] e,
		input logic [DATA_W-1:0] d);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_MODULUS;
		cfg_data <= n;
		@(posedge clk);
		cfg_index <= REG_PUB_EXP;
		cfg_data <= e;
		@(posedge clk);
		cfg_index <= REG_PRIV_EXP;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		keys_loaded++;
	endtask

	// values biased toward the interesting points around the modulus
	function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] n);
		case ($urandom_range(7, 0))
			0: return '0;
			1: return 1;
			2: return n - 1;
			3: return n;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [DATA_W-1:0] n;
		logic [DATA_W-1:0] e;
		logic [DATA_W-1:0] d;
		logic op;
		int drain_at;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODULUS;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_ENCRYPT;
		no_gaps = 1'b0;
		items_sent = 0;
		decrypts_sent = 0;
		keys_loaded = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key left by reset: modulus 2, both exponents 1
		send_item(OP_ENCRYPT, '0);
		send_item(OP_DECRYPT, '1);
		send_item(OP_ENCRYPT, 3);

		// widest modulus, all-ones public exponent (slowest item), zero private
		load_key('1, '1, '0);
		send_item(OP_ENCRYPT, '0);
		send_item(OP_ENCRYPT, 1);
		send_item(OP_ENCRYPT, 32'hFFFF_FFFE);
		send_item(OP_ENCRYPT, '1);          // equals the modulus, reduces to zero
		send_item(OP_DECRYPT, '1);          // zero exponent gives one
		send_item(OP_DECRYPT, 32'h1234_5678);

		// degenerate moduli one and zero: result is zero throughout
		load_key(1, 32'd65537, 32'd3);
		send_item(OP_ENCRYPT, 5);
		send_item(OP_DECRYPT, '1);
		load_key('0, '1, 32'd7);
		send_item(OP_ENCRYPT, 7);
		send_item(OP_DECRYPT, '0);

		// textbook key 61 * 53: encrypt and decrypt round trip
		load_key(32'd3233, 32'd17, 32'd2753);
		send_item(OP_ENCRYPT, 32'd65);
		send_item(OP_DECRYPT, 32'd2790);
		send_item(OP_ENCRYPT, 32'd3233);
		send_item(OP_DECRYPT, '1);

		// smallest legal modulus, zero public exponent, only the top private bit
		load_key(2, '0, 32'h8000_0000);
		send_item(OP_ENCRYPT, 1);
		send_item(OP_DECRYPT, 3);
		send_item(OP_DECRYPT, 2);

		// random key settings, each with a burst of random traffic
		for (int ph = 0; ph < RAND_KEYS; ph++) begin
			case (ph % 4)
				0: begin
					n = $urandom;
					e = $urandom;
					d = $urandom;
				end
				1: begin
					// tiny modulus and short exponents
					n = $urandom_range(255, 2);
					e = $urandom_range(15, 0);
					d = $urandom_range(255, 0);
				end
				2: begin
					// near-full modulus with the usual public exponent
					n = '1 - $urandom_range(64, 0);
					e = 32'd65537;
					d = $urandom;
				end
				default: begin
					// random bit lengths of modulus and exponents
					n = $urandom >> $urandom_range(24, 0);
					e = $urandom >> $urandom_range(31, 0);
					d = $urandom >> $urandom_range(31, 0);
				end
			endcase
			load_key(n, e, d);
			// some settings run back to back with no idling on either side
			no_gaps = (ph % 3 == 2);
			drain_at = $urandom_range(ITEMS_PER_KEY - 1, 1);
			for (int k = 0; k < ITEMS_PER_KEY; k++) begin
				// sender holds off once per setting until everything is back
				if (k == drain_at)
					wait_idle();
				op = 1'($urandom_range(1, 0));
				send_item(op, pick_value(n));
			end
		end

		// drain, then give any stray result time to show up
		no_gaps = 1'b0;
		wait_idle();
		repeat (MAX_LATENCY) @(posedge clk);

		$display("covered %0d items (%0d decrypt) over %0d key settings,",
			items_sent, decrypts_sent, keys_loaded);
		$display("incl. moduli 0 and 1, zero and all-ones exponents, values at the modulus");
		if (errors == 0 && outstanding == 0) begin
			$display("rsa_modular_exponentiation_unit regression: pass");
		end else begin
			$display("rsa_modular_exponentiation_unit regression: fail");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/rsame_pkg.sv
rtl/rsa_modular_exponentiation_unit.sv
rtl/rsame_check.sv
tb/rsame_checker.sv
tb/tb_top.sv
